>>> rtl/xvbr_pkg.sv
// ----------------------------------------------------------------------------
// xvbr_pkg: shared types and constants of the VBR header parser
// Result record, phase codes, field flags and the phase sequencing function.
// ----------------------------------------------------------------------------
package xvbr_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'h5869_6E67;   // "Xing"
    localparam logic [6:0]  TOC_LENGTH = 7'd100;
    localparam logic [6:0]  WORD_BYTES = 7'd4;

    // Flag bit positions in the flags word
    localparam int FLAG_FRAMES = 0;
    localparam int FLAG_BYTES  = 1;
    localparam int FLAG_TOC    = 2;
    localparam int FLAG_SCALE  = 3;

    typedef enum logic [2:0] {
        PH_MAGIC    = 3'd0,
        PH_FLAGS    = 3'd1,
        PH_FRAMES   = 3'd2,
        PH_BYTES    = 3'd3,
        PH_TOC      = 3'd4,
        PH_SCALE    = 3'd5,
        PH_COMPLETE = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TOC  = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  toc_index;
        logic [7:0]  toc_value;
        logic [31:0] flag_word;
        logic [31:0] frame_total;
        logic [31:0] byte_total;
        logic [31:0] quality_scale;
    } t_result;

    // Up to two results caused by one byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // Next phase after the given one, skipping fields whose flag is clear
    function automatic t_phase f_next_phase(t_phase from, logic [31:0] flags);
        t_phase p;
        p = PH_COMPLETE;
        case (from)
            PH_MAGIC, PH_FLAGS: begin
                if (flags[FLAG_FRAMES])      p = PH_FRAMES;
                else if (flags[FLAG_BYTES])  p = PH_BYTES;
                else if (flags[FLAG_TOC])    p = PH_TOC;
                else if (flags[FLAG_SCALE])  p = PH_SCALE;
            end
            PH_FRAMES: begin
                if (flags[FLAG_BYTES])       p = PH_BYTES;
                else if (flags[FLAG_TOC])    p = PH_TOC;
                else if (flags[FLAG_SCALE])  p = PH_SCALE;
            end
            PH_BYTES: begin
                if (flags[FLAG_TOC])         p = PH_TOC;
                else if (flags[FLAG_SCALE])  p = PH_SCALE;
            end
            PH_TOC: begin
                if (flags[FLAG_SCALE])       p = PH_SCALE;
            end
            default: begin
                p = PH_COMPLETE;
            end
        endcase
        return p;
    endfunction

endpackage

>>> rtl/xvbr_parse.sv
// ----------------------------------------------------------------------------
// xvbr_parse: header parsing state
// Holds the field phase, byte position and words read so far; on every
// accepted byte updates them and produces up to two results.
// ----------------------------------------------------------------------------
module xvbr_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output xvbr_pkg::t_push   o_push
);
    import xvbr_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [6:0]  r_pos,      n_pos;
    logic [31:0] r_shift,    n_shift;
    logic [31:0] r_flags,    n_flags;
    logic [31:0] r_frames,   n_frames;
    logic [31:0] r_bytes,    n_bytes;
    logic        r_settled,  n_settled;

    logic        toc_v;
    t_result     toc_res;
    logic        settle_v;
    t_result     settle_res;

    // Work out the state update and results for the byte on the input
    always_comb begin
        logic [6:0]  pos_inc;
        logic [31:0] shift_in;
        logic        advance;
        t_phase      adv_phase;

        n_phase   = r_phase;
        n_pos     = r_pos;
        n_shift   = r_shift;
        n_flags   = r_flags;
        n_frames  = r_frames;
        n_bytes   = r_bytes;
        n_settled = r_settled;
        toc_v     = 1'b0;
        toc_res   = '0;
        settle_v  = 1'b0;
        settle_res = '0;
        advance   = 1'b0;
        pos_inc   = r_pos + 7'd1;
        shift_in  = {r_shift[23:0], i_data_byte};

        if (!r_settled) begin
            if (r_phase == PH_TOC) begin
                // emit each table entry as it arrives
                toc_v             = 1'b1;
                toc_res.kind      = KIND_TOC;
                toc_res.toc_index = r_pos;
                toc_res.toc_value = i_data_byte;
                n_pos             = pos_inc;
                if (pos_inc >= TOC_LENGTH) advance = 1'b1;
            end else if (r_phase <= PH_SCALE) begin
                n_shift = shift_in;
                n_pos   = pos_inc;
                if (pos_inc >= WORD_BYTES) begin
                    case (r_phase)
                        PH_MAGIC: begin
                            if (shift_in != MAGIC_WORD) begin
                                n_flags   = '0;
                                n_frames  = '0;
                                n_bytes   = '0;
                                settle_v  = 1'b1;
                                settle_res.kind = KIND_FAIL;
                                n_settled = 1'b1;
                            end else begin
                                n_phase = PH_FLAGS;
                                n_pos   = '0;
                                n_shift = '0;
                            end
                        end
                        PH_FLAGS: begin
                            n_flags = shift_in;
                            advance = 1'b1;
                        end
                        PH_FRAMES: begin
                            n_frames = shift_in;
                            advance  = 1'b1;
                        end
                        PH_BYTES: begin
                            n_bytes = shift_in;
                            advance = 1'b1;
                        end
                        default: begin
                            // scale word closes the header
                            n_phase   = PH_COMPLETE;
                            settle_v  = 1'b1;
                            n_settled = 1'b1;
                            settle_res.kind          = KIND_OK;
                            settle_res.flag_word     = r_flags;
                            settle_res.frame_total   = r_flags[FLAG_FRAMES] ? r_frames : '0;
                            settle_res.byte_total    = r_flags[FLAG_BYTES] ? r_bytes : '0;
                            settle_res.quality_scale = r_flags[FLAG_SCALE] ? shift_in : '0;
                        end
                    endcase
                end
            end

            // move to the next flagged field, report success when none is left
            adv_phase = f_next_phase(r_phase, n_flags);
            if (advance) begin
                n_phase = adv_phase;
                n_pos   = '0;
                n_shift = '0;
                if (adv_phase == PH_COMPLETE) begin
                    settle_v  = 1'b1;
                    n_settled = 1'b1;
                    settle_res.kind          = KIND_OK;
                    settle_res.flag_word     = n_flags;
                    settle_res.frame_total   = n_flags[FLAG_FRAMES] ? n_frames : '0;
                    settle_res.byte_total    = n_flags[FLAG_BYTES] ? n_bytes : '0;
                    settle_res.quality_scale = '0;
                end
            end

            // data ended before the header was complete
            if (i_last_byte && !n_settled) begin
                n_flags    = '0;
                n_frames   = '0;
                n_bytes    = '0;
                settle_v   = 1'b1;
                settle_res = '0;
                settle_res.kind = KIND_FAIL;
                n_settled  = 1'b1;
            end
        end else begin
            adv_phase = r_phase;
        end

        // final byte: start over for the next frame
        if (i_last_byte) begin
            n_phase   = PH_MAGIC;
            n_pos     = '0;
            n_shift   = '0;
            n_flags   = '0;
            n_frames  = '0;
            n_bytes   = '0;
            n_settled = 1'b0;
        end
    end

    // Order results: table entry first, then the settling result
    always_comb begin
        o_push.count  = {toc_v & settle_v, toc_v ^ settle_v};
        o_push.first  = toc_v ? toc_res : settle_res;
        o_push.second = settle_res;
        if (!i_accept) o_push.count = 2'd0;
    end

    // Advance the parsing state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_pos     <= '0;
            r_shift   <= '0;
            r_flags   <= '0;
            r_frames  <= '0;
            r_bytes   <= '0;
            r_settled <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_shift   <= n_shift;
            r_flags   <= n_flags;
            r_frames  <= n_frames;
            r_bytes   <= n_bytes;
            r_settled <= n_settled;
        end
    end

endmodule

>>> rtl/xvbr_outq.sv
// ----------------------------------------------------------------------------
// xvbr_outq: result queue
// Four-entry register queue taking up to two results per cycle and
// delivering one per output transfer.
// ----------------------------------------------------------------------------
module xvbr_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xvbr_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output xvbr_pkg::t_result o_result
);
    import xvbr_pkg::*;

    t_result     r_entry [4];
    logic [1:0]  r_wr_ptr, n_wr_ptr;
    logic [1:0]  r_rd_ptr, n_rd_ptr;
    logic [2:0]  r_count,  n_count;
    logic        pop;

    // Keep room for the two results a byte can cause
    assign o_room   = (r_count <= 3'd2);
    assign o_valid  = (r_count != 3'd0);
    assign o_result = r_entry[r_rd_ptr];
    assign pop      = o_valid & i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, i_push.count} - {2'b00, pop};
    end

    // Hold pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write entries in order
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_entry[r_wr_ptr] <= i_push.first;
        if (i_push.count == 2'd2) r_entry[r_wr_ptr + 2'd1] <= i_push.second;
    end

endmodule

>>> rtl/xing_vbr_header_parser.sv
// ----------------------------------------------------------------------------
// xing_vbr_header_parser: VBR info header parser
// Parses the ancillary bytes of an audio frame for the "Xing" header and
// reports table entries and the header summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one ancillary byte per
//   transfer, most significant first; i_last_byte marks the frame's final byte.
//   Output channel (o_out_valid / i_out_ready) carries results: a table entry
//   per table byte, then one success or failure result per frame.
//   Each byte is parsed in the cycle it is taken; its results are registered in
//   a four-entry output queue. Throughput is one byte per cycle while the queue
//   has room; a byte causing two results (last table entry with success, or a
//   table entry cut short by the final byte) needs two output transfers, the
//   extra one absorbed by the queue.
//   o_in_ready drops while fewer than two queue entries are free, so a
//   stalled receiver backs up the input, losing nothing.
//   Reset (synchronous, active low) empties the queue and returns the parser
//   to the magic phase; after every final byte the parser also restarts.
// ----------------------------------------------------------------------------
module xing_vbr_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_toc_index,
    output logic [7:0]  o_toc_value,
    output logic [31:0] o_flag_word,
    output logic [31:0] o_frame_total,
    output logic [31:0] o_byte_total,
    output logic [31:0] o_quality_scale
);
    import xvbr_pkg::*;

    logic    room;
    logic    accept;
    t_push   push;
    t_result result;

    assign o_in_ready = room;
    assign accept     = i_in_valid & room;

    xvbr_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    xvbr_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    // Unpack the head result onto the output ports
    assign o_kind          = result.kind;
    assign o_toc_index     = result.toc_index;
    assign o_toc_value     = result.toc_value;
    assign o_flag_word     = result.flag_word;
    assign o_frame_total   = result.frame_total;
    assign o_byte_total    = result.byte_total;
    assign o_quality_scale = result.quality_scale;

endmodule
